// ===== rtl/core/proximity_dedup_point_table_core_macros.svh =====
// Assertion helpers shared by the RTL that checks itself.
`ifndef PROXIMITY_DEDUP_POINT_TABLE_CORE_MACROS_SVH
`define PROXIMITY_DEDUP_POINT_TABLE_CORE_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define PDPT_ASSERT_NOW(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("pdpt assertion failed");

// Next-cycle implication, switched off while reset is high.
`define PDPT_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("pdpt assertion failed");

`endif

// ===== rtl/core/pdpt_pkg.sv =====
package pdpt_pkg;

  // Table size used when the top level is not overridden.
  localparam int MAX_POINTS_DEF = 256;

  // Field widths.
  localparam int COORD_W     = 24;
  localparam int DIST_W      = 23;
  localparam int COUNT_OUT_W = 9;
  localparam int ENTRY_W     = 2 * COORD_W;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 16;

  // Reset value of the closeness threshold (0.5 m).
  localparam logic [DIST_W-1:0] DIST_RESET = 23'd512;

  // Status of the compare pipeline as seen by the controller.
  typedef struct packed {
    logic busy;       // a request is somewhere in the pipeline
    logic hit_valid;  // one compare result is presented this cycle
    logic hit;        // that stored point lies inside the box
  } cmp_stat_t;

endpackage

// ===== rtl/core/pdpt_ram.sv =====
module pdpt_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/pdpt_cmp.sv =====
module pdpt_cmp
  import pdpt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               rd_en,
  input  logic [COORD_W-1:0] point_x,
  input  logic [COORD_W-1:0] point_y,
  input  logic [ENTRY_W-1:0] stored_data,
  input  logic [DIST_W-1:0]  threshold,
  output cmp_stat_t          stat
);

  logic               data_valid;
  logic               diff_valid;
  logic [COORD_W:0]   abs_x;
  logic [COORD_W:0]   abs_y;
  logic               hit_valid;
  logic               hit;
  logic signed [COORD_W:0] diff_x;
  logic signed [COORD_W:0] diff_y;
  logic [COORD_W-1:0] stored_x;
  logic [COORD_W-1:0] stored_y;

  // The memory word holds x in the low half and y in the high half.
  assign stored_x = stored_data[COORD_W-1:0];
  assign stored_y = stored_data[ENTRY_W-1:COORD_W];

  // Differences are exact at one bit wider than the coordinates.
  assign diff_x = $signed({point_x[COORD_W-1], point_x})
                - $signed({stored_x[COORD_W-1], stored_x});
  assign diff_y = $signed({point_y[COORD_W-1], point_y})
                - $signed({stored_y[COORD_W-1], stored_y});

  // Pipeline valid flags: memory output, magnitude stage, compare stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      data_valid <= 1'b0;
      diff_valid <= 1'b0;
      hit_valid  <= 1'b0;
    end else begin
      data_valid <= rd_en;
      diff_valid <= data_valid;
      hit_valid  <= diff_valid;
    end
  end

  // Magnitude stage.
  always_ff @(posedge clk) begin
    abs_x <= diff_x[COORD_W] ? (COORD_W+1)'(1) + ~diff_x : diff_x;
    abs_y <= diff_y[COORD_W] ? (COORD_W+1)'(1) + ~diff_y : diff_y;
  end

  // Box test: both axes strictly below the threshold.
  always_ff @(posedge clk) begin
    hit <= (abs_x < {2'b00, threshold}) && (abs_y < {2'b00, threshold});
  end

  assign stat.busy      = data_valid | diff_valid | hit_valid;
  assign stat.hit_valid = hit_valid;
  assign stat.hit       = hit;

endmodule

// ===== rtl/core/proximity_dedup_point_table_core.sv =====
// Duplicate point filter: each request carries one 2-D point and is compared
// against every point already held in the table; it is a duplicate when some
// stored point is strictly closer than dupe_distance on both axes. Unique
// points are appended while there is room, and every request gives exactly one
// response with the unique, stored and full flags and the table count after
// the request. One request is handled at a time. With an empty table the scan
// is skipped; otherwise the point memory, which has one read port, is read
// one entry per cycle. The controller then waits until the three-stage compare
// pipeline has drained, writes the point back and loads the response register;
// that step waits while an earlier response is still held back, so a response
// that is held back stalls the next one. The input is ready again only once the
// controller is back in idle. The table needs no clearing pass after reset; the
// fill count alone marks which entries are valid.
module proximity_dedup_point_table_core
  import pdpt_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [DIST_W-1:0]      cfg_wr_data,    // dupe_distance
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // point_x, point_y
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // is_unique, was_stored,
                                                 // table_full, stored_count
);

  `include "proximity_dedup_point_table_core_macros.svh"

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]             state;
  logic [1:0]             state_next;
  logic [DIST_W-1:0]      dupe_distance;
  logic [CW-1:0]          count;
  logic [AW-1:0]          scan_addr;
  logic [COORD_W-1:0]     point_x;
  logic [COORD_W-1:0]     point_y;
  logic                   dupe;
  logic                   in_fire;
  logic                   done_fire;
  logic                   has_room;
  logic                   store;
  logic                   scan_last;
  logic [ENTRY_W-1:0]     rd_data;
  cmp_stat_t              cmp_stat;
  logic                   out_valid;
  logic                   out_unique;
  logic                   out_stored;
  logic                   out_full;
  logic [COUNT_OUT_W-1:0] out_count;

  // Threshold register.
  always_ff @(posedge clk) begin
    if (rst) begin
      dupe_distance <= DIST_RESET;
    end else if (cfg_wr_en) begin
      dupe_distance <= cfg_wr_data;
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign done_fire     = (state == S_DONE) && (!out_valid || m_axis_tready);
  assign has_room      = (count < CW'(MAX_POINTS));
  assign store         = !dupe && has_room;
  assign scan_last     = (CW'(scan_addr) == count - CW'(1));

  // Controller next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          state_next = (count == '0) ? S_DRAIN : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!cmp_stat.busy) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (done_fire) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request capture and scan address.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      point_x <= s_axis_tdata[COORD_W-1:0];
      point_y <= s_axis_tdata[ENTRY_W-1:COORD_W];
    end
    if (in_fire) begin
      scan_addr <= '0;
    end else if (state == S_SCAN) begin
      scan_addr <= scan_addr + AW'(1);
    end
  end

  // Duplicate flag collects hits from the compare pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      dupe <= 1'b0;
    end else if (in_fire) begin
      dupe <= 1'b0;
    end else if (cmp_stat.hit_valid && cmp_stat.hit) begin
      dupe <= 1'b1;
    end
  end

  // Fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (done_fire && store) begin
      count <= count + CW'(1);
    end
  end

  pdpt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_POINTS)
  ) u_ram (
    .clk    (clk),
    .wr_en  (done_fire && store),
    .wr_addr(count[AW-1:0]),
    .wr_data({point_y, point_x}),
    .rd_en  (state == S_SCAN),
    .rd_addr(scan_addr),
    .rd_data(rd_data)
  );

  pdpt_cmp u_cmp (
    .clk        (clk),
    .rst        (rst),
    .rd_en      (state == S_SCAN),
    .point_x    (point_x),
    .point_y    (point_y),
    .stored_data(rd_data),
    .threshold  (dupe_distance),
    .stat       (cmp_stat)
  );

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_fire) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      out_unique <= !dupe;
      out_stored <= store;
      out_full   <= !dupe && !has_room;
      out_count  <= store ? COUNT_OUT_W'(count + CW'(1)) : COUNT_OUT_W'(count);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000, out_count, out_full, out_stored, out_unique};

  // Checks on the block's own bookkeeping.
  `PDPT_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CW'(MAX_POINTS))
  `PDPT_ASSERT_NOW(a_flags, clk, rst, out_valid,
    (out_unique == (out_stored | out_full)) && !(out_stored && out_full))
  `PDPT_ASSERT_NEXT(a_store_inc, clk, rst, done_fire && store,
    count == $past(count) + CW'(1))
  `PDPT_ASSERT_NOW(a_idle_quiet, clk, rst, s_axis_tready, !cmp_stat.busy)

endmodule
